// ----- hdl/rrss_pkg.sv -----
package rrss_pkg;

   // Default configuration of the thread ring.
   localparam int RING_SIZE_DEFAULT  = 4;
   localparam int IDLE_INDEX_DEFAULT = 3;

   // Fixed field widths of the request and response channels.
   localparam int REQ_TYPE_WIDTH  = 3;
   localparam int SLEEP_WIDTH     = 32;
   localparam int THREAD_ID_WIDTH = 2;
   localparam int MASK_WIDTH      = 4;

   typedef logic [REQ_TYPE_WIDTH-1:0] req_code_type;

   // Request codes.
   localparam req_code_type REQ_TICK     = 3'd0;
   localparam req_code_type REQ_SCHEDULE = 3'd1;
   localparam req_code_type REQ_SLEEP    = 3'd2;
   localparam req_code_type REQ_BLOCK    = 3'd3;
   localparam req_code_type REQ_UNBLOCK  = 3'd4;

   typedef logic [1:0] thread_state_type;

   // Thread states.
   localparam thread_state_type ST_READY    = 2'd0;
   localparam thread_state_type ST_BLOCKED  = 2'd1;
   localparam thread_state_type ST_SLEEPING = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic tick_step;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_last;
      logic scan_done;
   } status_type;

endpackage

// ----- hdl/rrss_datapath.sv -----
module rrss_datapath #(
   parameter int RING_SIZE  = rrss_pkg::RING_SIZE_DEFAULT,
   parameter int IDLE_INDEX = rrss_pkg::IDLE_INDEX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rrss_pkg::req_code_type               req_type,
   input  logic [rrss_pkg::SLEEP_WIDTH-1:0]     req_sleep_ms,
   input  logic [rrss_pkg::THREAD_ID_WIDTH-1:0] req_thread_id,
   input  rrss_pkg::cmd_type                    cmd,
   output rrss_pkg::status_type                 sts,
   output logic [rrss_pkg::THREAD_ID_WIDTH-1:0] rsp_current_thread,
   output logic                                 rsp_switch_request,
   output logic [rrss_pkg::MASK_WIDTH-1:0]      rsp_ready_mask
);

   localparam int IW        = $clog2(RING_SIZE);
   localparam int IDLE_SLOT = (IDLE_INDEX < RING_SIZE) ? IDLE_INDEX : RING_SIZE - 1;

   // Per-thread state and the running thread.
   rrss_pkg::thread_state_type         status_ff  [RING_SIZE];
   rrss_pkg::thread_state_type         status_in  [RING_SIZE];
   logic [rrss_pkg::SLEEP_WIDTH-1:0]   counter_ff [RING_SIZE];
   logic [rrss_pkg::SLEEP_WIDTH-1:0]   counter_in [RING_SIZE];
   logic [IW-1:0]                      running_ff;
   logic [IW-1:0]                      running_in;

   // Walk step counter and ring position for the tick and schedule walks.
   logic [IW-1:0]                      walk_ff;
   logic [IW-1:0]                      walk_in;
   logic [IW-1:0]                      pos_ff;
   logic [IW-1:0]                      pos_in;
   logic                               switch_ff;

   // Response payload registers.
   logic [rrss_pkg::THREAD_ID_WIDTH-1:0] current_ff;
   logic                                 sw_rsp_ff;
   logic [rrss_pkg::MASK_WIDTH-1:0]      mask_ff;

   logic [IW-1:0]                      pos_next;
   logic [IW-1:0]                      sel_idx;
   rrss_pkg::thread_state_type         sel_state;
   logic [rrss_pkg::SLEEP_WIDTH-1:0]   sel_count;
   logic [IW-1:0]                      tid_idx;
   logic                               tid_in_ring;
   logic [rrss_pkg::MASK_WIDTH-1:0]    ready_mask;

   // Next ring position and the thread state read port shared by the tick and schedule walks.
   assign pos_next  = (pos_ff == IW'(RING_SIZE - 1)) ? '0 : pos_ff + IW'(1);
   assign sel_idx   = cmd.scan_step ? pos_next : walk_ff;
   assign sel_state = status_ff[sel_idx];
   assign sel_count = counter_ff[walk_ff];

   assign tid_idx     = IW'(req_thread_id);
   assign tid_in_ring = (int'(req_thread_id) < RING_SIZE);

   assign sts.walk_last = (walk_ff == IW'(RING_SIZE - 1));
   assign sts.scan_done = (sel_state == rrss_pkg::ST_READY) || sts.walk_last;

   // Ready bits of the first threads of the ring.
   for (genvar g = 0; g < rrss_pkg::MASK_WIDTH; g++) begin : g_mask
      if (g < RING_SIZE) begin : g_live
         assign ready_mask[g] = (status_ff[g] == rrss_pkg::ST_READY);
      end else begin : g_none
         assign ready_mask[g] = 1'b0;
      end
   end

   // Next-state logic for thread state, counters and walk registers.
   always_comb begin
      status_in  = status_ff;
      counter_in = counter_ff;
      running_in = running_ff;
      walk_in    = walk_ff;
      pos_in     = pos_ff;
      if (cmd.accept) begin
         walk_in = '0;
         pos_in  = running_ff;
         case (req_type)
            rrss_pkg::REQ_SLEEP: begin
               counter_in[running_ff] = req_sleep_ms;
               status_in[running_ff]  = rrss_pkg::ST_SLEEPING;
            end
            rrss_pkg::REQ_BLOCK: begin
               status_in[running_ff] = rrss_pkg::ST_BLOCKED;
            end
            rrss_pkg::REQ_UNBLOCK: begin
               if (tid_in_ring) begin
                  status_in[tid_idx] = rrss_pkg::ST_READY;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.tick_step) begin
         walk_in = walk_ff + IW'(1);
         if (sel_count != '0) begin
            counter_in[walk_ff] = sel_count - rrss_pkg::SLEEP_WIDTH'(1);
            if (sel_count == rrss_pkg::SLEEP_WIDTH'(1) &&
                sel_state == rrss_pkg::ST_SLEEPING) begin
               status_in[walk_ff] = rrss_pkg::ST_READY;
            end
         end
      end
      if (cmd.scan_step) begin
         walk_in = walk_ff + IW'(1);
         pos_in  = pos_next;
         if (sel_state == rrss_pkg::ST_READY) begin
            running_in = pos_next;
         end else if (sts.walk_last) begin
            running_in = IW'(IDLE_SLOT);
         end
      end
   end

   // Thread state registers, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_SIZE; i++) begin
            status_ff[i]  <= rrss_pkg::ST_READY;
            counter_ff[i] <= '0;
         end
         running_ff <= '0;
      end else begin
         status_ff  <= status_in;
         counter_ff <= counter_in;
         running_ff <= running_in;
      end
   end

   // Walk registers and payload registers, no reset needed.
   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      pos_ff  <= pos_in;
      if (cmd.accept) begin
         switch_ff <= (req_type == rrss_pkg::REQ_TICK) ||
                      (req_type == rrss_pkg::REQ_SLEEP) ||
                      (req_type == rrss_pkg::REQ_BLOCK);
      end
      if (cmd.load_rsp) begin
         current_ff <= rrss_pkg::THREAD_ID_WIDTH'(running_ff);
         sw_rsp_ff  <= switch_ff;
         mask_ff    <= ready_mask;
      end
   end

   assign rsp_current_thread = current_ff;
   assign rsp_switch_request = sw_rsp_ff;
   assign rsp_ready_mask     = mask_ff;

endmodule

// ----- hdl/rrss_controller.sv -----
module rrss_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrss_pkg::req_code_type req_type,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rrss_pkg::status_type   sts,
   output rrss_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_TICK,
      S_SCAN,
      S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Command decode and next state.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd.accept    = 1'b0;
      cmd.tick_step = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_type == rrss_pkg::REQ_TICK) begin
                  state_in = S_TICK;
               end else if (req_type == rrss_pkg::REQ_SCHEDULE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_TICK: begin
            cmd.tick_step = 1'b1;
            if (sts.walk_last) begin
               state_in = S_RESULT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and response valid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/round_robin_sleep_scheduler.sv -----
// Sleep, block, unblock and unknown requests go straight from acceptance to the
// response stage; tick walks the whole ring, and schedule walks it until a ready
// thread is found or the ring ends, one thread per cycle. The response is loaded
// once the output register is free.
// Requests are handled one at a time; the next is accepted while a response waits.
// Reset (synchronous) marks all threads ready, clears sleep counters and runs thread 0.
module round_robin_sleep_scheduler #(
   parameter int RING_SIZE  = rrss_pkg::RING_SIZE_DEFAULT,
   parameter int IDLE_INDEX = rrss_pkg::IDLE_INDEX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rrss_pkg::REQ_TYPE_WIDTH-1:0]  req_type,
   input  logic [rrss_pkg::SLEEP_WIDTH-1:0]     req_sleep_ms,
   input  logic [rrss_pkg::THREAD_ID_WIDTH-1:0] req_thread_id,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rrss_pkg::THREAD_ID_WIDTH-1:0] rsp_current_thread,
   output logic                                 rsp_switch_request,
   output logic [rrss_pkg::MASK_WIDTH-1:0]      rsp_ready_mask
);

   rrss_pkg::cmd_type    cmd;
   rrss_pkg::status_type sts;

   // Sequencing of each transaction.
   rrss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Thread state, sleep counters and response registers.
   rrss_datapath #(
      .RING_SIZE  (RING_SIZE),
      .IDLE_INDEX (IDLE_INDEX)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_sleep_ms       (req_sleep_ms),
      .req_thread_id      (req_thread_id),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_current_thread (rsp_current_thread),
      .rsp_switch_request (rsp_switch_request),
      .rsp_ready_mask     (rsp_ready_mask)
   );

   // At most one controller command is active in any cycle.
   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.tick_step, cmd.scan_step, cmd.load_rsp}))
      else $error("controller issued overlapping commands");

   // A new response only appears after the response registers were loaded.
   a_rsp_after_load : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("response valid rose without a load");

   // Requests without a ring walk go straight to the response stage.
   a_short_path : assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && (req_type == rrss_pkg::REQ_SLEEP || req_type == rrss_pkg::REQ_BLOCK ||
                      req_type == rrss_pkg::REQ_UNBLOCK))
      |=> (!cmd.tick_step && !cmd.scan_step && req_stall))
      else $error("single-cycle request started a ring walk");

endmodule

// ----- verif/tb_round_robin_sleep_scheduler.sv -----
`timescale 1ns / 1ps

module tb_round_robin_sleep_scheduler;

   localparam int RING_SIZE = rrss_pkg::RING_SIZE_DEFAULT;
   localparam int IDLE_INDEX = rrss_pkg::IDLE_INDEX_DEFAULT;
   localparam int IDLE_SLOT = (IDLE_INDEX < RING_SIZE) ? IDLE_INDEX : RING_SIZE - 1;
   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_ITEMS = 150;
   localparam int HOLD_AFTER = 200;
   localparam int HOLD_CYCLES = 90;

   // Request codes the block does not know; they must leave the state alone.
   localparam rrss_pkg::req_code_type REQ_UNUSED_FIRST = 3'd5;
   localparam rrss_pkg::req_code_type REQ_UNUSED_MID = 3'd6;
   localparam rrss_pkg::req_code_type REQ_UNUSED_LAST = 3'd7;

   typedef struct packed {
      logic [rrss_pkg::THREAD_ID_WIDTH-1:0] thread;
      logic                                 switch_req;
      logic [rrss_pkg::MASK_WIDTH-1:0]      mask;
   } sched_result_type;

   // Scheduler state mirror and the queue of responses still owed by the block.
   class sched_scoreboard;
      rrss_pkg::thread_state_type       thread_state[RING_SIZE];
      logic [rrss_pkg::SLEEP_WIDTH-1:0] sleep_count[RING_SIZE];
      int                               running;
      sched_result_type                 results_due[$];
      int                               failures;

      function new();
         for (int i = 0; i < RING_SIZE; i++) begin
            thread_state[i] = rrss_pkg::ST_READY;
            sleep_count[i] = '0;
         end
         running = 0;
         failures = 0;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // Advances the mirrored state by one request and returns the response it yields.
      function sched_result_type apply_request(rrss_pkg::req_code_type code,
                                               logic [rrss_pkg::SLEEP_WIDTH-1:0] ms,
                                               logic [rrss_pkg::THREAD_ID_WIDTH-1:0] tid);
         sched_result_type r;
         int pos;
         bit found;
         r = '0;
         case (code)
            rrss_pkg::REQ_TICK: begin
               for (int i = 0; i < RING_SIZE; i++) begin
                  if (sleep_count[i] != 0) begin
                     sleep_count[i] = sleep_count[i] - 1;
                     if (sleep_count[i] == 0 && thread_state[i] == rrss_pkg::ST_SLEEPING)
                        thread_state[i] = rrss_pkg::ST_READY;
                  end
               end
               r.switch_req = 1'b1;
            end
            rrss_pkg::REQ_SCHEDULE: begin
               // The current thread is looked at last; fall back to the idle thread.
               pos = running;
               found = 1'b0;
               for (int i = 0; i < RING_SIZE && !found; i++) begin
                  pos = (pos + 1) % RING_SIZE;
                  if (thread_state[pos] == rrss_pkg::ST_READY)
                     found = 1'b1;
               end
               running = found ? pos : IDLE_SLOT;
            end
            rrss_pkg::REQ_SLEEP: begin
               sleep_count[running] = ms;
               thread_state[running] = rrss_pkg::ST_SLEEPING;
               r.switch_req = 1'b1;
            end
            rrss_pkg::REQ_BLOCK: begin
               thread_state[running] = rrss_pkg::ST_BLOCKED;
               r.switch_req = 1'b1;
            end
            rrss_pkg::REQ_UNBLOCK: begin
               if (int'(tid) < RING_SIZE)
                  thread_state[tid] = rrss_pkg::ST_READY;
            end
            default: begin
            end
         endcase
         r.thread = running[rrss_pkg::THREAD_ID_WIDTH-1:0];
         for (int i = 0; i < RING_SIZE && i < rrss_pkg::MASK_WIDTH; i++)
            r.mask[i] = (thread_state[i] == rrss_pkg::ST_READY);
         return r;
      endfunction

      function void note_request(rrss_pkg::req_code_type code,
                                 logic [rrss_pkg::SLEEP_WIDTH-1:0] ms,
                                 logic [rrss_pkg::THREAD_ID_WIDTH-1:0] tid);
         results_due.push_back(apply_request(code, ms, tid));
      endfunction

      function void check_response(logic [rrss_pkg::THREAD_ID_WIDTH-1:0] thread,
                                   logic switch_req,
                                   logic [rrss_pkg::MASK_WIDTH-1:0] mask);
         sched_result_type want;
         if (results_due.size() == 0) begin
            $error("unexpected response: current_thread %0d switch_request %0b ready_mask %b",
                   thread, switch_req, mask);
            failures++;
            return;
         end
         want = results_due.pop_front();
         if (thread !== want.thread) begin
            $error("current_thread: expected %0d, actual %0d", want.thread, thread);
            failures++;
         end
         if (switch_req !== want.switch_req) begin
            $error("switch_request: expected %0b, actual %0b", want.switch_req, switch_req);
            failures++;
         end
         if (mask !== want.mask) begin
            $error("ready_mask: expected %b, actual %b", want.mask, mask);
            failures++;
         end
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [rrss_pkg::REQ_TYPE_WIDTH-1:0]  req_type;
   logic [rrss_pkg::SLEEP_WIDTH-1:0]     req_sleep_ms;
   logic [rrss_pkg::THREAD_ID_WIDTH-1:0] req_thread_id;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [rrss_pkg::THREAD_ID_WIDTH-1:0] rsp_current_thread;
   logic                                 rsp_switch_request;
   logic [rrss_pkg::MASK_WIDTH-1:0]      rsp_ready_mask;

   sched_scoreboard board;
   int requests_accepted = 0;
   bit calm_phase = 1'b0;
   bit holding = 1'b0;

   round_robin_sleep_scheduler #(
      .RING_SIZE (RING_SIZE),
      .IDLE_INDEX(IDLE_INDEX)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_sleep_ms      (req_sleep_ms),
      .req_thread_id     (req_thread_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_thread(rsp_current_thread),
      .rsp_switch_request(rsp_switch_request),
      .rsp_ready_mask    (rsp_ready_mask)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Offers one request and holds it until the block takes the transaction.
   task automatic send_request(rrss_pkg::req_code_type code,
                               logic [rrss_pkg::SLEEP_WIDTH-1:0] ms,
                               logic [rrss_pkg::THREAD_ID_WIDTH-1:0] tid);
      req_valid <= 1'b1;
      req_type <= code;
      req_sleep_ms <= ms;
      req_thread_id <= tid;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_request(code, ms, tid);
      requests_accepted++;
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Mostly kernel-like traffic: ticks and schedules, with sleeps, blocks, wakeups and unknown codes.
   task automatic send_random_item();
      int pick;
      int sel;
      rrss_pkg::req_code_type code;
      logic [rrss_pkg::SLEEP_WIDTH-1:0] ms;
      logic [rrss_pkg::THREAD_ID_WIDTH-1:0] tid;
      pick = $urandom_range(0, 99);
      ms = $urandom;
      tid = rrss_pkg::THREAD_ID_WIDTH'($urandom_range(0, RING_SIZE - 1));
      if (pick < 28) begin
         code = rrss_pkg::REQ_TICK;
      end else if (pick < 52) begin
         code = rrss_pkg::REQ_SCHEDULE;
      end else if (pick < 68) begin
         code = rrss_pkg::REQ_SLEEP;
         sel = $urandom_range(0, 9);
         if (sel < 7)
            ms = $urandom_range(1, 6);
         else if (sel == 7)
            ms = '0;
      end else if (pick < 76) begin
         code = rrss_pkg::REQ_BLOCK;
      end else if (pick < 95) begin
         code = rrss_pkg::REQ_UNBLOCK;
      end else begin
         code = rrss_pkg::req_code_type'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      end
      send_request(code, ms, tid);
   endtask

   // Response checker; a transaction completes when valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_current_thread, rsp_switch_request, rsp_ready_mask);
   end

   // Receiver back-pressure in random bursts, with long holds just past HOLD_AFTER requests to fill the block up.
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (!holding && requests_accepted >= HOLD_AFTER &&
             requests_accepted < HOLD_AFTER + 5) begin
            holding = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            holding = 1'b0;
         end else if (calm_phase) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #(12 * 600000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= rrss_pkg::REQ_TICK;
      req_sleep_ms <= '0;
      req_thread_id <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk: forever sleep, longest sleep, idle thread blocked with a
      // running counter, nothing ready, wakeups and unknown codes.
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);
      send_request(rrss_pkg::REQ_SLEEP, '0, '0);
      send_request(rrss_pkg::REQ_TICK, '0, '0);
      send_request(rrss_pkg::REQ_TICK, '1, '1);
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);
      send_request(rrss_pkg::REQ_SLEEP, '1, '1);
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);
      send_request(rrss_pkg::REQ_SLEEP, 32'd2, '0);
      send_request(rrss_pkg::REQ_BLOCK, '0, '0);
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);
      send_request(rrss_pkg::REQ_BLOCK, '0, '0);
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);
      send_request(rrss_pkg::REQ_TICK, '0, '0);
      send_request(rrss_pkg::REQ_TICK, '0, '0);
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);
      send_request(rrss_pkg::REQ_UNBLOCK, '1, 2'd0);
      send_request(rrss_pkg::REQ_UNBLOCK, '0, 2'd1);
      send_request(rrss_pkg::REQ_UNBLOCK, '0, 2'd2);
      send_request(rrss_pkg::REQ_UNBLOCK, '0, 2'd3);
      send_request(REQ_UNUSED_FIRST, '1, '1);
      send_request(REQ_UNUSED_MID, 32'h5A5A_A5A5, 2'd2);
      send_request(REQ_UNUSED_LAST, '0, '0);
      send_request(rrss_pkg::REQ_SLEEP, 32'd1, 2'd3);
      send_request(rrss_pkg::REQ_TICK, '0, '0);
      send_request(rrss_pkg::REQ_SCHEDULE, '0, '0);

      // Random traffic; the sender idles in bursts except during a long hold
      // and the calm tail of the run.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - CALM_ITEMS)
            calm_phase = 1'b1;
         if (!calm_phase && !holding && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 18));
         send_random_item();
      end
      req_valid <= 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (RING_SIZE + 10) @(posedge clock);

      if (board.failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- round_robin_sleep_scheduler.f -----
hdl/rrss_pkg.sv
hdl/rrss_datapath.sv
hdl/rrss_controller.sv
hdl/round_robin_sleep_scheduler.sv
verif/tb_round_robin_sleep_scheduler.sv
